/* hw/rtl/sdaf_pkg.sv */
// ----------------------------------------------------------------------------
// sdaf_pkg
// shared widths, character codes, queue entry type and the place value table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdaf_pkg;

   localparam int VALUE_WIDTH         = 32;
   localparam int CHAR_WIDTH          = 8;
   localparam int DIGIT_COUNT         = 10;
   localparam int IDX_WIDTH           = $clog2(DIGIT_COUNT);
   localparam int DIGIT_WIDTH         = 4;
   // 9 * 10^9 needs 34 bits
   localparam int WIDE_WIDTH          = VALUE_WIDTH + 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(DIGIT_COUNT - 1);

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   // decimal weight of digit position, most significant first
   function automatic logic [WIDE_WIDTH-1:0] place_value(input logic [IDX_WIDTH-1:0] idx);
      case (idx)
         0:       place_value = WIDE_WIDTH'(1000000000);
         1:       place_value = WIDE_WIDTH'(100000000);
         2:       place_value = WIDE_WIDTH'(10000000);
         3:       place_value = WIDE_WIDTH'(1000000);
         4:       place_value = WIDE_WIDTH'(100000);
         5:       place_value = WIDE_WIDTH'(10000);
         6:       place_value = WIDE_WIDTH'(1000);
         7:       place_value = WIDE_WIDTH'(100);
         8:       place_value = WIDE_WIDTH'(10);
         default: place_value = WIDE_WIDTH'(1);
      endcase
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sdaf_front.sv */
// ----------------------------------------------------------------------------
// sdaf_front
// input side: takes an item, splits it into sign and magnitude
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdaf_front
   import sdaf_pkg::*;
(
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [VALUE_WIDTH-1:0] req_tdata,   // [31:0] value
   input  logic                          queue_full,
   output slot_type                      push
);

   logic negative;

   assign negative   = req_tdata[VALUE_WIDTH-1];
   assign req_tready = !queue_full;

   always_comb begin
      push.valid          = req_tvalid && !queue_full;
      push.entry.negative = negative;
      // two's complement magnitude, also exact for the most negative value
      push.entry.magnitude = negative ? (~req_tdata + VALUE_WIDTH'(1)) : req_tdata;
   end

endmodule

`default_nettype wire

/* hw/rtl/sdaf_queue.sv */
// ----------------------------------------------------------------------------
// sdaf_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdaf_queue
   import sdaf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  slot_type push,
   output logic     full,
   input  logic     pop,
   output slot_type head
);

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(QUEUE_DEPTH);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == COUNT_MAX);
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sdaf_back.sv */
// ----------------------------------------------------------------------------
// sdaf_back
// digit sequencer: one decimal position per cycle, while rsp is not stalled, into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdaf_back
   import sdaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  slot_type              head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_WIDTH-1:0] rsp_tdata,   // [7:0] character
   output logic                  rsp_tlast
);

   logic                   busy_ff, busy_in;
   logic                   sign_ff, sign_in;
   logic                   started_ff, started_in;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;

   logic [WIDE_WIDTH-1:0]  place;
   logic [WIDE_WIDTH-1:0]  multiple [1:9];
   logic [WIDE_WIDTH-1:0]  sub;
   logic [DIGIT_WIDTH-1:0] digit;
   logic [VALUE_WIDTH-1:0] rem_next;
   logic                   emit_digit, out_free, step, finishing, load;

   // largest multiple of the place value that fits in the remainder
   always_comb begin
      place = place_value(idx_ff);
      digit = '0;
      sub   = '0;
      for (int d = 1; d <= 9; d++) begin
         multiple[d] = place * WIDE_WIDTH'(d);
         if ({2'b00, rem_ff} >= multiple[d]) begin
            digit = DIGIT_WIDTH'(d);
            sub   = multiple[d];
         end
      end
      rem_next = rem_ff - sub[VALUE_WIDTH-1:0];
   end

   // leading zeros dropped, units digit always shown
   assign emit_digit = (digit != '0) || started_ff || (idx_ff == LAST_IDX);
   assign out_free   = !valid_ff || rsp_tready;
   assign step       = busy_ff && out_free;
   assign finishing  = step && !sign_ff && (idx_ff == LAST_IDX);
   assign load       = head.valid && (!busy_ff || finishing);
   assign pop        = load;

   always_comb begin
      busy_in    = busy_ff;
      sign_in    = sign_ff;
      started_in = started_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      valid_in   = out_free ? 1'b0 : valid_ff;
      char_in    = char_ff;
      last_in    = last_ff;

      if (step) begin
         if (sign_ff) begin
            sign_in  = 1'b0;
            valid_in = 1'b1;
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
         end else begin
            valid_in   = emit_digit;
            char_in    = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit};
            last_in    = (idx_ff == LAST_IDX);
            started_in = emit_digit;
            rem_in     = rem_next;
            idx_in     = idx_ff + IDX_WIDTH'(1);
         end
      end

      if (finishing) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in    = 1'b1;
         sign_in    = head.entry.negative;
         started_in = 1'b0;
         idx_in     = '0;
         rem_in     = head.entry.magnitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff    <= sign_in;
      started_ff <= started_in;
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/signed_decimal_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// signed 32-bit integer to decimal ascii text, one character per item
// ----------------------------------------------------------------------------
// req channel: one item is a signed 32-bit value in req_tdata, taken when
//    req_tvalid and req_tready are both high
// rsp channel: one item is one ascii character in rsp_tdata; rsp_tlast
//    marks the final character of each number
// text: optional '-', then digits with leading zeros dropped; zero gives "0"
// path: with the back end free, a req item passes a queue entry and the
//    sequencer registers before its first character reaches the output
//    register; each dropped leading zero adds a sequencer step with no
//    character before the first digit shows
// sequencer: one decimal position per cycle while rsp is not stalled, all
//    ten per number, plus a step for a minus sign
// a queued next number loads in the same cycle the units digit is produced
// req_tready stays high while the queue has room, so items queue up while
//    an earlier number is still being printed
// rsp stall: the output register holds its character and the sequencer
//    waits; once the queue fills, req_tready drops
// reset: clears the queue and the sequencer; no output is pending after it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_ascii_formatter
   import sdaf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [VALUE_WIDTH-1:0] req_tdata,   // [31:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [CHAR_WIDTH-1:0]         rsp_tdata,   // [7:0] character
   output logic                          rsp_tlast
);

   slot_type push;     // classified item from the front
   slot_type head;     // oldest queued item
   logic     queue_full;
   logic     pop;

   // front: sign and magnitude split
   sdaf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   // decouples intake from character output
   sdaf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   // back: digit by digit conversion into the output register
   sdaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks signed_decimal_ascii_formatter against its own decimal text predictor,
// directed edge values then mostly random integers of every length, with
// random idle cycles on both the req and the rsp side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// one expected character of a number's text
typedef struct {
   logic [sdaf_pkg::CHAR_WIDTH-1:0] ch;
   logic                            last;
} char_item;

// holds the text of every accepted number, oldest character first
class text_scoreboard;
   char_item text_q[$];
   int       errors;

   function new();
      errors = 0;
   endfunction

   // build the decimal text of one accepted value
   function void note_value(input logic [31:0] value);
      logic          negative;
      int unsigned   mag;
      int unsigned   weight;
      int unsigned   digit;
      bit            started;
      char_item      item;
      negative = value[31];
      mag      = negative ? (~value + 32'd1) : value;
      started  = 1'b0;
      weight   = 32'd1000000000;
      if (negative) begin
         item.ch   = sdaf_pkg::CHAR_MINUS;
         item.last = 1'b0;
         text_q.push_back(item);
      end
      for (int k = 0; k < 10; k++) begin
         digit = (mag / weight) % 10;
         // units digit always printed, so zero gives "0"
         if (digit != 0 || started || k == 9) begin
            started   = 1'b1;
            item.ch   = sdaf_pkg::CHAR_ZERO + 8'(digit);
            item.last = (k == 9);
            text_q.push_back(item);
         end
         weight = weight / 10;
      end
   endfunction

   // compare one accepted character with the oldest expected one
   function void check_char(input logic [7:0] ch, input logic last);
      char_item want;
      if (text_q.size() == 0) begin
         $display("%0t: unexpected character, expected none actual %h last %b",
                  $time, ch, last);
         errors++;
         return;
      end
      want = text_q.pop_front();
      if (ch !== want.ch) begin
         $display("%0t: character expected %h actual %h", $time, want.ch, ch);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last expected %b actual %b", $time, want.last, last);
         errors++;
      end
   endfunction

   function int pending();
      return text_q.size();
   endfunction
endclass

module tb;
   import sdaf_pkg::*;

   localparam int RANDOM_COUNT = 440;
   // random items in this index range go out without idle cycles
   localparam int CALM_FIRST   = 200;
   localparam int CALM_LAST    = 290;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic signed [VALUE_WIDTH-1:0] req_tdata;    // [31:0] value
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [CHAR_WIDTH-1:0]         rsp_tdata;    // [7:0] character
   logic                          rsp_tlast;

   // both sides drop their idling while this is set
   logic           calm;
   text_scoreboard text_sb;

   signed_decimal_ascii_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // offer one value, with random idle cycles ahead of it, until it is taken
   task automatic send_value(input logic [31:0] value);
      while (!calm && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      // sampled values here are the ones seen at the edge
      while (!req_tready) @(posedge clock);
      text_sb.note_value(value);
   endtask

   // random value, weighted toward every text length and both signs
   function automatic logic [31:0] pick_value();
      int unsigned span;
      logic [31:0] v;
      case ($urandom_range(3))
         0: v = $urandom();
         1: begin
            // pick a digit count first, so short numbers show up often
            span = 1;
            repeat ($urandom_range(1, 9)) span = span * 10;
            v = $urandom_range(span - 1);
            if ($urandom_range(1)) v = ~v + 32'd1;
         end
         2: begin
            // powers of ten and their neighbors, around each new digit
            span = 1;
            repeat ($urandom_range(0, 9)) span = span * 10;
            v = span + 32'($urandom_range(2)) - 32'd1;
            if ($urandom_range(1)) v = ~v + 32'd1;
         end
         default: v = 32'($signed($urandom_range(40)) - 20);
      endcase
      return v;
   endfunction

   // result side: check every accepted character, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) text_sb.check_char(rsp_tdata, rsp_tlast);
         rsp_tready <= calm || ($urandom_range(99) >= 33);
      end
   end

   // stimulus and end of run
   initial begin
      logic [31:0] directed_values[$];
      text_sb    = new();
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      calm       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero, the most negative value, the largest and other digit-count edges
      directed_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10,
                          32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h7FFFFFFE,
                          32'd1000000000, -32'sd1000000000, 32'd999999999,
                          -32'sd999999999, 32'd100, 32'd1000000, 32'd1000000007,
                          32'h55555555, 32'hAAAAAAAA, -32'sd9, 32'd1234567890};
      foreach (directed_values[i]) send_value(directed_values[i]);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         send_value(pick_value());
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then watch a little longer for stray characters
      while (text_sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      if (text_sb.errors == 0 && text_sb.pending() == 0) begin
         $display("signed_decimal_ascii_formatter: match");
      end else begin
         $display("signed_decimal_ascii_formatter: mismatch");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("signed_decimal_ascii_formatter: mismatch");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/sdaf_pkg.sv
hw/rtl/sdaf_front.sv
hw/rtl/sdaf_queue.sv
hw/rtl/sdaf_back.sv
hw/rtl/signed_decimal_ascii_formatter.sv
bench/tb.sv
